FILE: rtl/stl_pkg.sv
// Shared types, kind codes and classification functions for the source token lexer.
package stl_pkg;

  localparam int unsigned KwMaxLen = 9;
  localparam int unsigned OffBits  = 32;
  localparam int unsigned LenBits  = 16;
  localparam int unsigned KindBits = 7;
  localparam int unsigned KwIdxBits = 4;

  localparam logic [KindBits-1:0] KString  = 7'd0;
  localparam logic [KindBits-1:0] KFloat   = 7'd1;
  localparam logic [KindBits-1:0] KInteger = 7'd2;
  localparam logic [KindBits-1:0] KWords   = 7'd3;
  localparam logic [KindBits-1:0] KIdent   = 7'd26;
  localparam logic [KindBits-1:0] KNewline = 7'd67;
  localparam logic [KindBits-1:0] KUnknown = 7'd68;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_INT, MODE_FRAC, MODE_STR, MODE_CR, MODE_OP
  } mode_e;

  // One token handed from the front to the back.
  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [OffBits-1:0]  start;
    logic [LenBits-1:0]  length;
    logic                last;
  } token_t;

  typedef logic [7:0] word_buf_t [KwMaxLen];

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    case (b)
      "&", "|", "+", "-", "*", "/", "%", "^", "<", ">", "!", "=", ".": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // form: 0 single, 1 with '=', 2 doubled, 3 doubled with '='
  function automatic logic [KindBits-1:0] op_kind(input logic [7:0] c, input logic [1:0] form);
    logic f;
    f = (form != 2'd0);
    case (c)
      "&": return f ? 7'd37 : 7'd38;
      "|": return f ? 7'd39 : 7'd40;
      "+": return f ? 7'd41 : 7'd42;
      "-": return f ? 7'd43 : 7'd44;
      "*": return f ? 7'd45 : 7'd46;
      "/": return f ? 7'd47 : 7'd48;
      "%": return f ? 7'd49 : 7'd50;
      "^": return f ? 7'd51 : 7'd52;
      "<": return (form == 2'd0) ? 7'd56 : (form == 2'd1) ? 7'd53 :
                  (form == 2'd2) ? 7'd59 : 7'd58;
      ">": return (form == 2'd0) ? 7'd60 : (form == 2'd1) ? 7'd57 :
                  (form == 2'd2) ? 7'd55 : 7'd54;
      "!": return f ? 7'd61 : 7'd62;
      "=": return f ? 7'd63 : 7'd64;
      default: return f ? 7'd65 : 7'd66;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] single_kind(input logic [7:0] b);
    case (b)
      "(": return 7'd27;
      ")": return 7'd28;
      "{": return 7'd29;
      "}": return 7'd30;
      "[": return 7'd31;
      "]": return 7'd32;
      ";": return 7'd33;
      ":": return 7'd34;
      "_": return 7'd35;
      " ": return 7'd36;
      8'h0a: return KNewline;
      default: return KUnknown;
    endcase
  endfunction

  function automatic logic [8*KwMaxLen-1:0] kw_text(input int unsigned i);
    case (i)
      0: return 72'("and");        1: return 72'("or");
      2: return 72'("if");         3: return 72'("elif");
      4: return 72'("else");       5: return 72'("break");
      6: return 72'("while");      7: return 72'("loop");
      8: return 72'("for");        9: return 72'("in");
      10: return 72'("component"); 11: return 72'("enum");
      12: return 72'("struct");    13: return 72'("impl");
      14: return 72'("my");        15: return 72'("true");
      16: return 72'("false");     17: return 72'("i32");
      18: return 72'("i64");       19: return 72'("f32");
      20: return 72'("f64");       21: return 72'("str");
      default: return 72'("bool");
    endcase
  endfunction

  function automatic logic [KwIdxBits-1:0] kw_len(input int unsigned i);
    case (i)
      1, 2, 9, 14: return 4'd2;
      0, 8, 17, 18, 19, 20, 21: return 4'd3;
      5, 6, 16: return 4'd5;
      12: return 4'd6;
      10: return 4'd9;
      default: return 4'd4;
    endcase
  endfunction

  // String literals are right-aligned: character j of a word of length n
  // sits at byte n-1-j.
  function automatic logic [KindBits-1:0] word_kind(input word_buf_t wb,
                                                     input logic [LenBits-1:0] len);
    logic [KindBits-1:0] k;
    logic [8*KwMaxLen-1:0] t;
    logic hit;
    int unsigned n;
    k = KIdent;
    for (int unsigned i = 0; i < 23; i++) begin
      t = kw_text(i);
      n = 32'(kw_len(i));
      hit = (len == LenBits'(n));
      for (int unsigned j = 0; j < KwMaxLen; j++) begin
        if (j < n && wb[j] != t[8*(n-1-j) +: 8]) hit = 1'b0;
      end
      if (hit && k == KIdent) k = KWords + KindBits'(i);
    end
    return k;
  endfunction

endpackage

FILE: rtl/stl_front.sv
// Front end: scans bytes, keeps pending-token state, emits up to two tokens per byte.
module stl_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  output logic                      out_valid_o,
  output logic [1:0]                out_count_o,
  output stl_pkg::token_t           out_tok0_o,
  output stl_pkg::token_t           out_tok1_o
);

  stl_pkg::mode_e                   mode_q, mode_d;
  stl_pkg::word_buf_t               wbuf_q, wbuf_d;
  logic [stl_pkg::LenBits-1:0]      plen_q, plen_d;
  logic [stl_pkg::OffBits-1:0]      pstart_q, pstart_d;
  logic [stl_pkg::OffBits-1:0]      off_q, off_d;
  logic [7:0]                       pop_q, pop_d;
  logic                             deep_q, deep_d;

  logic [1:0]                       cnt;
  stl_pkg::token_t                  t0, t1;
  logic                             consumed;
  logic [stl_pkg::LenBits-1:0]      len_inc;
  logic [7:0]                       b;

  assign b = in_byte_i;
  assign len_inc = (plen_q == '1) ? plen_q : plen_q + 1'b1;

  always_comb begin
    stl_pkg::token_t tk;
    mode_d = mode_q; wbuf_d = wbuf_q; plen_d = plen_q; pstart_d = pstart_q;
    off_d = off_q; pop_d = pop_q; deep_d = deep_q;
    cnt = 2'd0; t0 = '0; t1 = '0; consumed = 1'b0; tk = '0;
    tk.start = pstart_q;
    // Offer the byte to the pending token.
    unique case (mode_q)
      stl_pkg::MODE_WORD: begin
        if (stl_pkg::is_alpha(b) || stl_pkg::is_digit(b)) begin
          for (int unsigned j = 0; j < stl_pkg::KwMaxLen; j++)
            if (plen_q == stl_pkg::LenBits'(j)) wbuf_d[j] = b;
          plen_d = len_inc; consumed = 1'b1;
        end else begin
          tk.kind = stl_pkg::word_kind(wbuf_q, plen_q); tk.length = plen_q;
          t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end
      end
      stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
        if (stl_pkg::is_digit(b)) begin
          plen_d = len_inc; consumed = 1'b1;
        end else if (b == "." && mode_q == stl_pkg::MODE_INT) begin
          plen_d = len_inc; consumed = 1'b1; mode_d = stl_pkg::MODE_FRAC;
        end else begin
          tk.kind = (mode_q == stl_pkg::MODE_INT) ? stl_pkg::KInteger : stl_pkg::KFloat;
          tk.length = plen_q; t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end
      end
      stl_pkg::MODE_STR: begin
        plen_d = len_inc; consumed = 1'b1;
        if (b == 8'h22) begin
          tk.kind = stl_pkg::KString; tk.length = len_inc;
          t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end
      end
      stl_pkg::MODE_CR: begin
        tk.kind = stl_pkg::KNewline;
        tk.length = (b == 8'h0a) ? stl_pkg::LenBits'(2) : stl_pkg::LenBits'(1);
        consumed = (b == 8'h0a);
        t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
      end
      stl_pkg::MODE_OP: begin
        if (deep_q) begin
          consumed = (b == "=");
          tk.kind = stl_pkg::op_kind(pop_q, consumed ? 2'd3 : 2'd2);
          tk.length = consumed ? stl_pkg::LenBits'(3) : stl_pkg::LenBits'(2);
          t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end else if (pop_q == "." && b == ".") begin
          tk.kind = stl_pkg::op_kind(pop_q, 2'd2); tk.length = stl_pkg::LenBits'(2);
          consumed = 1'b1; t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end else if (pop_q != "." && b == "=") begin
          tk.kind = stl_pkg::op_kind(pop_q, 2'd1); tk.length = stl_pkg::LenBits'(2);
          consumed = 1'b1; t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end else if ((pop_q == "<" || pop_q == ">") && b == pop_q) begin
          deep_d = 1'b1; consumed = 1'b1;
        end else begin
          tk.kind = stl_pkg::op_kind(pop_q, 2'd0); tk.length = stl_pkg::LenBits'(1);
          t0 = tk; cnt = 2'd1; mode_d = stl_pkg::MODE_IDLE;
        end
      end
      default: mode_d = stl_pkg::MODE_IDLE;
    endcase

    // Start a new token with an unconsumed byte.
    if (!consumed) begin
      tk = '0; tk.start = off_q; tk.length = stl_pkg::LenBits'(1);
      pstart_d = off_q; plen_d = stl_pkg::LenBits'(1);
      if (stl_pkg::is_op(b)) begin
        mode_d = stl_pkg::MODE_OP; pop_d = b; deep_d = 1'b0;
      end else if (b == 8'h0d) begin
        mode_d = stl_pkg::MODE_CR;
      end else if (b == 8'h22) begin
        mode_d = stl_pkg::MODE_STR;
      end else if (stl_pkg::is_digit(b)) begin
        mode_d = stl_pkg::MODE_INT;
      end else if (stl_pkg::is_alpha(b)) begin
        mode_d = stl_pkg::MODE_WORD; wbuf_d[0] = b;
      end else begin
        tk.kind = stl_pkg::single_kind(b);
        if (cnt == 2'd0) t0 = tk; else t1 = tk;
        cnt = cnt + 2'd1;
      end
    end

    if (in_last_i) begin
      // Flush whatever is pending; at most one token is left here.
      tk = '0; tk.start = pstart_d; tk.length = plen_d;
      case (mode_d)
        stl_pkg::MODE_WORD: tk.kind = stl_pkg::word_kind(wbuf_d, plen_d);
        stl_pkg::MODE_INT:  tk.kind = stl_pkg::KInteger;
        stl_pkg::MODE_FRAC: tk.kind = stl_pkg::KFloat;
        stl_pkg::MODE_STR:  tk.kind = stl_pkg::KString;
        stl_pkg::MODE_CR: begin
          tk.kind = stl_pkg::KNewline; tk.length = stl_pkg::LenBits'(1);
        end
        stl_pkg::MODE_OP: begin
          tk.kind = stl_pkg::op_kind(pop_d, deep_d ? 2'd2 : 2'd0);
          tk.length = deep_d ? stl_pkg::LenBits'(2) : stl_pkg::LenBits'(1);
        end
        default: tk.kind = stl_pkg::KUnknown;
      endcase
      if (mode_d != stl_pkg::MODE_IDLE) begin
        if (cnt == 2'd0) t0 = tk; else t1 = tk;
        cnt = cnt + 2'd1;
      end
      if (cnt == 2'd1) t0.last = 1'b1;
      if (cnt == 2'd2) t1.last = 1'b1;
      mode_d = stl_pkg::MODE_IDLE; plen_d = '0; pstart_d = '0; off_d = '0;
      pop_d = '0; deep_d = 1'b0;
      for (int unsigned j = 0; j < stl_pkg::KwMaxLen; j++) wbuf_d[j] = '0;
    end else begin
      off_d = off_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stl_pkg::MODE_IDLE;
      plen_q <= '0; pstart_q <= '0; off_q <= '0; pop_q <= '0; deep_q <= 1'b0;
      for (int unsigned j = 0; j < stl_pkg::KwMaxLen; j++) wbuf_q[j] <= '0;
    end else if (in_valid_i) begin
      mode_q <= mode_d; plen_q <= plen_d; pstart_q <= pstart_d; off_q <= off_d;
      pop_q <= pop_d; deep_q <= deep_d; wbuf_q <= wbuf_d;
    end
  end

  assign out_valid_o = in_valid_i && (cnt != 2'd0);
  assign out_count_o = cnt;
  assign out_tok0_o  = t0;
  assign out_tok1_o  = t1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_last_i) |=> (mode_q == stl_pkg::MODE_IDLE && off_q == '0))
    else $error("state not cleared after end of text");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == stl_pkg::MODE_OP && deep_q) |-> (pop_q == "<" || pop_q == ">"))
    else $error("doubled operator other than a shift");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && cnt == 2'd2) |-> !t0.last)
    else $error("last flag on first of two tokens");

endmodule

FILE: rtl/stl_queue.sv
// Token queue between front and back; each entry write takes up to two tokens.
module stl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  logic [1:0]      wr_count_i,
  input  stl_pkg::token_t wr_tok0_i,
  input  stl_pkg::token_t wr_tok1_i,
  output logic            wr_room_o,
  output logic            rd_valid_o,
  output stl_pkg::token_t rd_tok_o,
  input  logic            rd_ready_i
);

  localparam int unsigned Depth = 8;
  stl_pkg::token_t mem_q [Depth];
  logic [2:0] wptr_q, rptr_q;
  logic [3:0] cnt_q;
  logic rd;
  logic [3:0] cnt_d;

  assign rd = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (cnt_q != 4'd0);
  assign rd_tok_o = mem_q[rptr_q];
  assign wr_room_o = (cnt_q <= 4'(Depth - 2));
  assign cnt_d = cnt_q + (wr_valid_i ? {2'b00, wr_count_i} : 4'd0) - {3'b000, rd};

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wptr_q] <= wr_tok0_i;
      if (wr_count_i == 2'd2) mem_q[wptr_q + 3'd1] <= wr_tok1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0; rptr_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_valid_i) wptr_q <= wptr_q + wr_count_i[1:0] + 3'd0;
      if (rd) rptr_q <= rptr_q + 3'd1;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 4'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> (wr_count_i != 2'd0 && wr_count_i != 2'd3))
    else $error("bad write count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 4'd0) |-> !rd)
    else $error("read from empty queue");

endmodule

FILE: rtl/source_token_lexer.sv
// Top level of the source token lexer: byte front end, token queue, output port.
// The front end classifies each byte combinationally; completed tokens are registered in the queue and read from it.
// Throughput: one byte per cycle while the queue has room; two tokens from one byte are read out one at a time.
// The 8-entry token queue holds back input when fewer than two slots are free.
// Reset (rst_ni low, asynchronous) idles the lexer, zeroes the offset, empties the queue.
module source_token_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [6:0] token_kind, [38:7] token_start,
                                      // [54:39] token_length, [55] pad
  output logic        m_axis_tlast    // last_token
);

  logic            fr_valid;
  logic [1:0]      fr_count;
  stl_pkg::token_t fr_tok0, fr_tok1, q_tok;
  logic            room;

  assign s_axis_tready = room;

  stl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && room),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (fr_valid),
    .out_count_o (fr_count),
    .out_tok0_o  (fr_tok0),
    .out_tok1_o  (fr_tok1)
  );

  stl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_count_i (fr_count),
    .wr_tok0_i  (fr_tok0),
    .wr_tok1_i  (fr_tok1),
    .wr_room_o  (room),
    .rd_valid_o (m_axis_tvalid),
    .rd_tok_o   (q_tok),
    .rd_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, q_tok.length, q_tok.start, q_tok.kind};
  assign m_axis_tlast = q_tok.last;

endmodule
